FILE: hw/rtl/html_tag_strip_space_collapse_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tag stripper
// Shared concurrent assertion forms, each checked on the rising clock edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef HTML_TAG_STRIP_SPACE_COLLAPSE_MACROS_SVH
`define HTML_TAG_STRIP_SPACE_COLLAPSE_MACROS_SVH

// Same-cycle implication
`define HTSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define HTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/htsc_pkg.sv
// ----------------------------------------------------------------------------
// htsc_pkg
// Shared constants, codes and the classified-byte record passed from the
// front end through the queue to the back end.
// ----------------------------------------------------------------------------
package htsc_pkg;

    // Lookahead window length (8 to 16); the window keeps one spare slot so a
    // final byte can join a full window before the body is flushed.
    localparam int LOOKAHEAD = 8;
    localparam int WIN_DEPTH = LOOKAHEAD + 1;
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);

    // Judged byte, then "/script" and one delimiter after it
    localparam int VIEW_LEN = 9;

    // Queue between front and back (power of two)
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Hidden-region kinds
    localparam logic [1:0] HID_NONE   = 2'd0;
    localparam logic [1:0] HID_STYLE  = 2'd1;
    localparam logic [1:0] HID_SCRIPT = 2'd2;

    // Characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUEST = 8'h3f;

    typedef logic [VIEW_LEN-1:0][7:0] view_t;

    // One judged byte with the facts the back end needs about its lookahead
    typedef struct packed {
        logic [7:0] data;
        logic       tag_start;     // '<' then letter, '/', '!' or '?'
        logic       open_style;    // "style" + delimiter after the '<'
        logic       open_script;   // "script" + delimiter after the '<'
        logic       close_style;   // "</style" + delimiter
        logic       close_script;  // "</script" + delimiter
        logic       is_gt;
        logic       is_ws;         // whitespace or control byte
        logic       fin;           // judged during the body-end flush
        logic       last;          // final judged byte of the body
        logic       empty;         // body ended with nothing to judge
    } entry_t;

endpackage

FILE: hw/rtl/html_tag_strip_space_collapse.sv
// ----------------------------------------------------------------------------
// html_tag_strip_space_collapse: markup stripper with whitespace collapse
// Throughput one byte per cycle while no body-end flush or full queue stalls input;
// a collapsed space is sent on a back-end pass of its own. A byte is judged when
// the eighth byte after it arrives; its result reaches m_tvalid through the queue,
// then the output register. Body end blocks input while the window drains,
// longer while the queue is full.
// Reset is asynchronous, active low; window bytes are not cleared.
// ----------------------------------------------------------------------------
module html_tag_strip_space_collapse
    import htsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tlast,    // end_of_body
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tuser,    // [0] byte_valid
    output logic       m_tlast     // is_last
);

    logic   push;
    entry_t push_entry;
    logic   q_full;
    entry_t head;
    logic   head_valid;
    logic   pop;

    // Window and classifier
    htsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    // Decoupling queue
    htsc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // Tag tracking, space collapse, output beat
    htsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: hw/rtl/htsc_front.sv
// ----------------------------------------------------------------------------
// htsc_front
// Lookahead window and byte classifier. Holds incoming bytes until enough
// follow them, then classifies the oldest one and pushes it to the queue.
// At body end, flushes every held byte, one per cycle while the queue has room.
// ----------------------------------------------------------------------------
module htsc_front
    import htsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tlast,
    output logic       push,
    output entry_t     push_entry,
    input  logic       q_full
);

    logic [7:0]       win_reg  [WIN_DEPTH];
    logic [7:0]       win_next [WIN_DEPTH];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             flush_reg;
    logic             flush_next;
    logic             accept;
    logic             in_fin;
    logic             in_nz;
    view_t            run_view;
    view_t            flush_view;
    entry_t           cls;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? 8'(c + 8'd32) : c;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
               c == CH_GT || c == CH_SLASH;
    endfunction

    function automatic logic match_style(input view_t v, input int off);
        return to_lower(v[off]) == "s" && to_lower(v[off + 1]) == "t" &&
               to_lower(v[off + 2]) == "y" && to_lower(v[off + 3]) == "l" &&
               to_lower(v[off + 4]) == "e" && is_delim(v[off + 5]);
    endfunction

    function automatic logic match_script(input view_t v, input int off);
        return to_lower(v[off]) == "s" && to_lower(v[off + 1]) == "c" &&
               to_lower(v[off + 2]) == "r" && to_lower(v[off + 3]) == "i" &&
               to_lower(v[off + 4]) == "p" && to_lower(v[off + 5]) == "t" &&
               is_delim(v[off + 6]);
    endfunction

    // v[0] is the judged byte, v[1..] the bytes after it
    function automatic entry_t classify(input view_t v);
        entry_t e;
        logic   lt;
        e              = '0;
        lt             = v[0] == CH_LT;
        e.data         = v[0];
        e.tag_start    = lt && (is_alpha(v[1]) || v[1] == CH_SLASH ||
                                v[1] == CH_BANG || v[1] == CH_QUEST);
        e.open_style   = match_style(v, 1);
        e.open_script  = match_script(v, 1);
        e.close_style  = lt && v[1] == CH_SLASH && match_style(v, 2);
        e.close_script = lt && v[1] == CH_SLASH && match_script(v, 2);
        e.is_gt        = v[0] == CH_GT;
        e.is_ws        = v[0] <= CH_SPACE;
        return e;
    endfunction

    // Stall input while flushing, or when a full window needs queue space
    assign s_tready = !flush_reg && ((cnt_reg < CNT_W'(LOOKAHEAD)) || !q_full);
    assign accept   = s_tvalid && s_tready;
    assign in_nz    = s_tdata != 8'h00;
    assign in_fin   = s_tlast || !in_nz;

    // Build the running view (full window plus new byte) and the flush view
    always_comb
    begin
        for (int k = 0; k < VIEW_LEN; k++)
        begin
            run_view[k]   = (k < LOOKAHEAD) ? win_reg[k] : s_tdata;
            flush_view[k] = (CNT_W'(k) < cnt_reg) ? win_reg[k] : 8'h00;
        end
    end

    assign cls = classify(flush_reg ? flush_view : run_view);

    // Advance the window, push classified bytes
    always_comb
    begin
        win_next   = win_reg;
        cnt_next   = cnt_reg;
        flush_next = flush_reg;
        push       = 1'b0;
        push_entry = cls;
        if (flush_reg)
        begin
            if (!q_full)
            begin
                push = 1'b1;
                if (cnt_reg == '0)
                begin
                    push_entry       = '0;
                    push_entry.fin   = 1'b1;
                    push_entry.last  = 1'b1;
                    push_entry.empty = 1'b1;
                    flush_next       = 1'b0;
                end
                else
                begin
                    push_entry.fin  = 1'b1;
                    push_entry.last = cnt_reg == CNT_W'(1);
                    for (int k = 0; k < WIN_DEPTH - 1; k++)
                    begin
                        win_next[k] = win_reg[k + 1];
                    end
                    cnt_next = CNT_W'(cnt_reg - 1'b1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        flush_next = 1'b0;
                    end
                end
            end
        end
        else if (accept)
        begin
            if (in_fin)
            begin
                // Append a nonzero final byte, then flush
                if (in_nz)
                begin
                    for (int k = 0; k < WIN_DEPTH; k++)
                    begin
                        if (cnt_reg == CNT_W'(k))
                        begin
                            win_next[k] = s_tdata;
                        end
                    end
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end
                flush_next = 1'b1;
            end
            else if (cnt_reg == CNT_W'(LOOKAHEAD))
            begin
                // Push out the oldest byte and shift in the new one
                push = 1'b1;
                for (int k = 0; k < LOOKAHEAD - 1; k++)
                begin
                    win_next[k] = win_reg[k + 1];
                end
                win_next[LOOKAHEAD-1] = s_tdata;
            end
            else
            begin
                for (int k = 0; k < WIN_DEPTH; k++)
                begin
                    if (cnt_reg == CNT_W'(k))
                    begin
                        win_next[k] = s_tdata;
                    end
                end
                cnt_next = CNT_W'(cnt_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
        end
    end

    // Window contents carry no reset; slots past the fill count are masked
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

FILE: hw/rtl/htsc_fifo.sv
// ----------------------------------------------------------------------------
// htsc_fifo
// Short queue of classified bytes between the front and back ends, so that
// either side can stall without stopping the other.
// ----------------------------------------------------------------------------
module htsc_fifo
    import htsc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   head_valid
);

    entry_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = count_reg == FIFO_CW'(FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = FIFO_CW'(count_reg + 1'b1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = FIFO_CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= FIFO_AW'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= FIFO_AW'(rd_ptr_reg + 1'b1);
            end
            count_reg <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hw/rtl/htsc_back.sv
// ----------------------------------------------------------------------------
// htsc_back
// Tag/hidden-region tracking and whitespace collapse on classified bytes.
// Drives the output register; during a body-end flush one result is held
// back so the final one can be tagged as last.
// ----------------------------------------------------------------------------
module htsc_back
    import htsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  entry_t     head,
    input  logic       head_valid,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tuser,    // [0] byte_valid
    output logic       m_tlast
);

    // Judge state
    logic       inside_reg, inside_next, inside_j;
    logic [1:0] hidden_reg, hidden_next, hidden_j;
    logic       lws_reg, lws_next, lws_j;
    logic       sp_reg, sp_next, sp_j;
    logic       end_reg, end_next;

    // Held result during flush
    logic       p_valid_reg, p_valid_next;
    logic [7:0] p_byte_reg, p_byte_next;

    // Output register
    logic       o_valid_reg, o_valid_next;
    logic [7:0] o_byte_reg, o_byte_next;
    logic       o_bv_reg, o_bv_next;
    logic       o_last_reg, o_last_next;
    logic       o_load;

    logic       hid;
    logic       closes;
    logic       emit_space;
    logic       emit_byte;
    logic       emit_any;
    logic       can_emit;
    logic       emit_ok;
    logic [7:0] res_byte;

    // Judge the head byte against the current state
    always_comb
    begin
        hid        = (hidden_reg == HID_STYLE) || (hidden_reg == HID_SCRIPT);
        closes     = (hidden_reg == HID_STYLE) ? head.close_style : head.close_script;
        inside_j   = inside_reg;
        hidden_j   = hidden_reg;
        lws_j      = lws_reg;
        sp_j       = sp_reg;
        emit_space = 1'b0;
        emit_byte  = 1'b0;
        if (!(hid && !closes))
        begin
            if (hid)
            begin
                hidden_j = HID_NONE;
            end
            if (inside_reg)
            begin
                if (head.is_gt)
                begin
                    inside_j = 1'b0;
                end
            end
            else if (head.tag_start)
            begin
                inside_j = 1'b1;
                if (head.open_style)
                begin
                    hidden_j = HID_STYLE;
                end
                else if (head.open_script)
                begin
                    hidden_j = HID_SCRIPT;
                end
            end
            else if (head.is_ws)
            begin
                if (!lws_reg)
                begin
                    sp_j  = 1'b1;
                    lws_j = 1'b1;
                end
            end
            else if (sp_reg)
            begin
                // Send the pending space now, the byte itself on the next pass
                emit_space = 1'b1;
                sp_j       = 1'b0;
            end
            else
            begin
                emit_byte = 1'b1;
                lws_j     = 1'b0;
            end
        end
    end

    assign emit_any = emit_space || emit_byte;
    assign can_emit = !o_valid_reg || m_tready;
    assign res_byte = emit_space ? CH_SPACE : head.data;
    assign emit_ok  = !emit_any || (head.fin ? (!p_valid_reg || can_emit) : can_emit);

    // Sequence results into the output register
    always_comb
    begin
        pop          = 1'b0;
        inside_next  = inside_reg;
        hidden_next  = hidden_reg;
        lws_next     = lws_reg;
        sp_next      = sp_reg;
        end_next     = end_reg;
        p_valid_next = p_valid_reg;
        p_byte_next  = p_byte_reg;
        o_load       = 1'b0;
        o_byte_next  = o_byte_reg;
        o_bv_next    = o_bv_reg;
        o_last_next  = o_last_reg;
        if (end_reg)
        begin
            // Close the body: held result as last, or a bare end marker
            if (can_emit)
            begin
                o_load       = 1'b1;
                o_byte_next  = p_valid_reg ? p_byte_reg : 8'h00;
                o_bv_next    = p_valid_reg;
                o_last_next  = 1'b1;
                p_valid_next = 1'b0;
                end_next     = 1'b0;
            end
        end
        else if (head_valid)
        begin
            if (head.empty)
            begin
                pop         = 1'b1;
                end_next    = 1'b1;
                inside_next = 1'b0;
                hidden_next = HID_NONE;
                lws_next    = 1'b1;
                sp_next     = 1'b0;
            end
            else if (emit_ok)
            begin
                inside_next = inside_j;
                hidden_next = hidden_j;
                lws_next    = lws_j;
                sp_next     = sp_j;
                pop         = !emit_space;
                if (emit_any)
                begin
                    if (head.fin)
                    begin
                        if (p_valid_reg)
                        begin
                            o_load      = 1'b1;
                            o_byte_next = p_byte_reg;
                            o_bv_next   = 1'b1;
                            o_last_next = 1'b0;
                        end
                        p_valid_next = 1'b1;
                        p_byte_next  = res_byte;
                    end
                    else
                    begin
                        o_load      = 1'b1;
                        o_byte_next = res_byte;
                        o_bv_next   = 1'b1;
                        o_last_next = 1'b0;
                    end
                end
                // Last byte of the body: return the judge state to its reset values, close the body
                if (!emit_space && head.last)
                begin
                    end_next    = 1'b1;
                    inside_next = 1'b0;
                    hidden_next = HID_NONE;
                    lws_next    = 1'b1;
                    sp_next     = 1'b0;
                end
            end
        end
        o_valid_next = o_load || (o_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg  <= 1'b0;
            hidden_reg  <= HID_NONE;
            lws_reg     <= 1'b1;
            sp_reg      <= 1'b0;
            end_reg     <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            inside_reg  <= inside_next;
            hidden_reg  <= hidden_next;
            lws_reg     <= lws_next;
            sp_reg      <= sp_next;
            end_reg     <= end_next;
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        p_byte_reg <= p_byte_next;
        if (o_load)
        begin
            o_byte_reg <= o_byte_next;
            o_bv_reg   <= o_bv_next;
            o_last_reg <= o_last_next;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_byte_reg;
    assign m_tuser  = o_bv_reg;
    assign m_tlast  = o_last_reg;

endmodule

FILE: hw/rtl/htsc_checker.sv
// ----------------------------------------------------------------------------
// htsc_checker
// Port-level checks on the output stream: end markers, trailing and doubled
// spaces, and a stalled beat holding its content.
// ----------------------------------------------------------------------------
`include "html_tag_strip_space_collapse_macros.svh"

module htsc_checker
    import htsc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    logic out_space;
    logic prev_space_reg;

    assign out_space = m_tuser && (m_tdata == CH_SPACE);

    // Remember whether the last delivered beat was a space
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_space_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            prev_space_reg <= out_space && !m_tlast;
        end
    end

    `HTSC_ASSERT_IMPLY(a_marker_is_last, clk, rst_n, m_tvalid && !m_tuser, m_tlast, "bare end marker without tlast")
    `HTSC_ASSERT_IMPLY(a_no_trailing_space, clk, rst_n, m_tvalid && out_space, !m_tlast, "space sent as last beat")
    `HTSC_ASSERT_IMPLY(a_no_double_space, clk, rst_n, m_tvalid && prev_space_reg, !out_space, "two spaces in a row")
    `HTSC_ASSERT_NEXT(a_stall_holds, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled beat changed")

endmodule

bind html_tag_strip_space_collapse htsc_checker u_htsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the markup stripper with space collapse
// Drives body bytes on the slave stream and checks every output beat against a
// cycle-free predictor of the stripper. A short directed table comes first,
// then bodies built from random markup tokens, under several idling phases.
// ----------------------------------------------------------------------------
module tb_top;
    import htsc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 88;
    localparam int HOLD_CYCLES  = 300;
    localparam int DIR_ROWS     = 25;
    localparam int DRAIN_CYCLES = LOOKAHEAD + 8;
    localparam int MAX_REPORTS  = 50;

    localparam logic [39:0] STYLE_NAME  = "style";
    localparam logic [47:0] SCRIPT_NAME = "script";

    typedef struct {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       is_last;
    } text_beat_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       eob;
        logic       typed;      // expected beat given below
        logic [7:0] exp_byte;
        logic       exp_valid;
        logic       exp_last;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    // Expected visible text, oldest first
    text_beat_t exp_text_q [$];
    int         err_cnt = 0;
    int         cycle_cnt = 0;
    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;
    int         random_sent = 0;
    logic       hold_req = 1'b0;
    logic       hold_seen = 1'b0;
    int         hold_left = 0;

    // Stripper state mirrored by the predictor
    logic [7:0]  win_q [LOOKAHEAD];
    int unsigned win_fill;
    bit          in_tag;
    logic [1:0]  hid_kind;
    bit          prev_space;
    bit          space_wait;
    logic [7:0]  view_buf [2*LOOKAHEAD+2];
    int          step_results;

    // Random body under construction
    logic [7:0] body_q [$];

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1},   // empty body right after reset
        '{8'hff, 1'b1, 1'b1, 8'hff, 1'b1, 1'b1},   // single top byte
        '{8'h20, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},   // lone space is dropped
        '{"a",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},   // control byte collapses
        '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"<",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},   // '<' before a digit is text
        '{"3",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},   // zero byte with end flag
        '{"<",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"S",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"T",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"Y",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"L",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"E",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{">",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"k",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},   // hidden style text
        '{"<",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"/",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"s",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"t",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"y",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"l",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"e",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{">",   1'b1, 1'b1, 8'h00, 1'b0, 1'b1}    // body ends with no text
    };

    html_tag_strip_space_collapse u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void clear_body_state();
        win_fill   = 0;
        in_tag     = 1'b0;
        hid_kind   = HID_NONE;
        prev_space = 1'b1;
        space_wait = 1'b0;
    endfunction

    function automatic void emit_text(logic [7:0] b, logic valid);
        text_beat_t t;
        t.out_byte   = b;
        t.byte_valid = valid;
        t.is_last    = 1'b0;
        exp_text_q.push_back(t);
        step_results++;
    endfunction

    function automatic bit is_delim(logic [7:0] d);
        return d == CH_SPACE || d == CH_TAB || d == CH_LF || d == CH_CR ||
               d == CH_GT || d == CH_SLASH;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // Case-blind name match at view_buf[pos], then a delimiter
    function automatic bit name_hit(int pos, bit want_script);
        int         len;
        logic [47:0] nm;
        logic [7:0] c;
        len = want_script ? 6 : 5;
        nm  = want_script ? SCRIPT_NAME : {8'h00, STYLE_NAME};
        for (int k = 0; k < len; k++)
        begin
            c = view_buf[pos+k];
            if (c >= "A" && c <= "Z")
                c = c + 8'd32;
            if (c != nm[8*(len-1-k) +: 8])
                return 1'b0;
        end
        return is_delim(view_buf[pos+len]);
    endfunction

    // Judge the byte at view_buf[pos] with the bytes after it in view
    function automatic void judge_byte(int pos);
        logic [7:0] b;
        logic [7:0] nx;
        b  = view_buf[pos];
        nx = view_buf[pos+1];
        if (hid_kind == HID_STYLE || hid_kind == HID_SCRIPT)
        begin
            if (!(b == CH_LT && nx == CH_SLASH && name_hit(pos + 2, hid_kind == HID_SCRIPT)))
                return;
            hid_kind = HID_NONE;
        end
        if (in_tag)
        begin
            if (b == CH_GT)
                in_tag = 1'b0;
            return;
        end
        if (b == CH_LT && (is_letter(nx) || nx == CH_SLASH || nx == CH_BANG || nx == CH_QUEST))
        begin
            in_tag = 1'b1;
            if (name_hit(pos + 1, 1'b0))
                hid_kind = HID_STYLE;
            else if (name_hit(pos + 1, 1'b1))
                hid_kind = HID_SCRIPT;
            return;
        end
        if (b <= CH_SPACE)
        begin
            if (!prev_space)
            begin
                space_wait = 1'b1;
                prev_space = 1'b1;
            end
            return;
        end
        if (space_wait)
        begin
            emit_text(CH_SPACE, 1'b1);
            space_wait = 1'b0;
        end
        emit_text(b, 1'b1);
        prev_space = 1'b0;
    endfunction

    // Advance the mirrored stripper by one accepted body byte
    function automatic void predict_body_byte(logic [7:0] b, logic eob);
        bit         fin;
        int         n;
        text_beat_t t;
        fin = eob || b == 8'h00;
        step_results = 0;
        foreach (view_buf[i])
            view_buf[i] = 8'h00;
        for (int i = 0; i < win_fill; i++)
            view_buf[i] = win_q[i];
        n = win_fill;
        if (b != 8'h00)
        begin
            view_buf[n] = b;
            n++;
        end
        if (!fin)
        begin
            if (n > LOOKAHEAD)
            begin
                judge_byte(0);
                for (int i = 0; i < LOOKAHEAD; i++)
                    win_q[i] = view_buf[i+1];
                win_fill = LOOKAHEAD;
            end
            else
            begin
                for (int i = 0; i < n; i++)
                    win_q[i] = view_buf[i];
                win_fill = n;
            end
            return;
        end
        // Flush the window at body end
        for (int i = 0; i < n; i++)
            judge_byte(i);
        if (step_results == 0)
            emit_text(8'h00, 1'b0);
        t = exp_text_q.pop_back();
        t.is_last = 1'b1;
        exp_text_q.push_back(t);
        clear_body_state();
    endfunction

    // ------------------------------------------------------------------------
    // Random body tokens
    // ------------------------------------------------------------------------
    function automatic void add_name(bit scr);
        int         len;
        logic [47:0] nm;
        logic [7:0] c;
        len = scr ? 6 : 5;
        nm  = scr ? SCRIPT_NAME : {8'h00, STYLE_NAME};
        for (int k = 0; k < len; k++)
        begin
            c = nm[8*(len-1-k) +: 8];
            if ($urandom_range(1) == 1)
                c = c - 8'd32;
            body_q.push_back(c);
        end
    endfunction

    function automatic void add_word();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0:       body_q.push_back(8'("a" + $urandom_range(25)));
                1:       body_q.push_back(8'("A" + $urandom_range(25)));
                2:       body_q.push_back(8'("0" + $urandom_range(9)));
                default: body_q.push_back(8'($urandom_range(33, 255)));
            endcase
        end
    endfunction

    function automatic void add_space_run();
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(4))
                0:       body_q.push_back(CH_SPACE);
                1:       body_q.push_back(CH_TAB);
                2:       body_q.push_back(CH_LF);
                3:       body_q.push_back(CH_CR);
                default: body_q.push_back(8'($urandom_range(1, 31)));
            endcase
        end
    endfunction

    function automatic logic [7:0] pick_delim();
        case ($urandom_range(5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_CR;
            4:       return CH_GT;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic void add_token(bit text_only);
        bit         scr;
        logic [7:0] d;
        if (text_only)
        begin
            add_word();
            return;
        end
        case ($urandom_range(13))
            3, 4: add_space_run();
            5:
            begin
                // Plain tag, possibly closing, comment or directive
                body_q.push_back(CH_LT);
                case ($urandom_range(3))
                    0: body_q.push_back(CH_SLASH);
                    1: body_q.push_back(CH_BANG);
                    2: body_q.push_back(CH_QUEST);
                    default: ;
                endcase
                body_q.push_back(8'("a" + $urandom_range(25)));
                if ($urandom_range(1) == 1)
                    add_space_run();
                add_word();
                body_q.push_back(CH_GT);
            end
            6, 7:
            begin
                // Style or script block, closing name sometimes off
                scr = $urandom_range(1);
                body_q.push_back(CH_LT);
                add_name(scr);
                d = pick_delim();
                body_q.push_back(d);
                if (d != CH_GT)
                begin
                    add_word();
                    body_q.push_back(CH_GT);
                end
                repeat ($urandom_range(3))
                begin
                    case ($urandom_range(3))
                        0: add_word();
                        1: add_space_run();
                        2: body_q.push_back(CH_LT);
                        default: body_q.push_back(CH_GT);
                    endcase
                end
                body_q.push_back(CH_LT);
                body_q.push_back(CH_SLASH);
                add_name($urandom_range(5) == 0 ? !scr : scr);
                body_q.push_back($urandom_range(5) == 0 ? 8'("x") : pick_delim());
                body_q.push_back(CH_GT);
            end
            8:
            begin
                // Near misses of a tag opening
                body_q.push_back(CH_LT);
                case ($urandom_range(4))
                    0: body_q.push_back("3");
                    1: body_q.push_back(CH_SPACE);
                    2: body_q.push_back(CH_LT);
                    3: body_q.push_back("=");
                    default:
                    begin
                        add_name($urandom_range(1));
                        body_q.push_back("s");
                        body_q.push_back(CH_GT);
                    end
                endcase
            end
            9:  body_q.push_back(8'($urandom_range(1, 255)));
            10: body_q.push_back(8'($urandom_range(128, 255)));
            11: body_q.push_back($urandom_range(1) ? CH_LT : CH_GT);
            default: add_word();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Slave-side driving
    // ------------------------------------------------------------------------
    task automatic send_beat(logic [7:0] b, logic eob);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eob;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_body_byte(b, eob);
    endtask

    task automatic send_random_body(int target, bit text_only);
        int end_kind;
        int n;
        body_q.delete();
        while (body_q.size() < target)
            add_token(text_only);
        // Cut some bodies short, inside tags and hidden blocks alike
        if ($urandom_range(2) == 0)
            while (body_q.size() > target)
                void'(body_q.pop_back());
        end_kind = $urandom_range(7);
        n = body_q.size();
        for (int i = 0; i < n; i++)
            send_beat(body_q[i], end_kind >= 3 && i == n - 1);
        if (end_kind < 3)
        begin
            send_beat(8'h00, end_kind == 2);
            n++;
        end
        random_sent += n;
    endtask

    // ------------------------------------------------------------------------
    // Master-side ready: random stalls plus one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_req && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Check each output beat against the oldest expectation
    always @(posedge clk)
    begin : chk_out
        text_beat_t t;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (exp_text_q.size() == 0)
            begin
                if (err_cnt < MAX_REPORTS)
                    $display("%0t: unexpected beat, actual byte=%h valid=%b last=%b",
                             $time, m_tdata, m_tuser, m_tlast);
                err_cnt++;
            end
            else
            begin
                t = exp_text_q.pop_front();
                if (m_tdata !== t.out_byte)
                begin
                    if (err_cnt < MAX_REPORTS)
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, t.out_byte, m_tdata);
                    err_cnt++;
                end
                if (m_tuser !== t.byte_valid)
                begin
                    if (err_cnt < MAX_REPORTS)
                        $display("%0t: byte_valid expected %b actual %b",
                                 $time, t.byte_valid, m_tuser);
                    err_cnt++;
                end
                if (m_tlast !== t.is_last)
                begin
                    if (err_cnt < MAX_REPORTS)
                        $display("%0t: is_last expected %b actual %b",
                                 $time, t.is_last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        text_beat_t t;
        dir_row_t   row;
        int         target;
        clear_body_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = dir_rows[r];
            send_beat(row.in_byte, row.eob);
            if (row.typed)
            begin
                if (step_results != 1)
                begin
                    $display("%0t: row %0d expected 1 beat, predicted %0d",
                             $time, r, step_results);
                    err_cnt++;
                end
                else
                begin
                    t = exp_text_q[exp_text_q.size()-1];
                    if (t.out_byte !== row.exp_byte || t.byte_valid !== row.exp_valid ||
                        t.is_last !== row.exp_last)
                    begin
                        $display("%0t: row %0d expected %h/%b/%b, predicted %h/%b/%b",
                                 $time, r, row.exp_byte, row.exp_valid, row.exp_last,
                                 t.out_byte, t.byte_valid, t.is_last);
                        err_cnt++;
                    end
                end
            end
        end

        // Random bodies, one idling mix per phase
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 60; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 60; end
                default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
            endcase
            if (ph == 0)
            begin
                // Hold off the receiver while a long text body streams in
                hold_req <= 1'b1;
                send_random_body(60, 1'b1);
            end
            while (random_sent < PHASE_ITEMS * (ph + 1))
            begin
                target = ($urandom_range(9) < 7) ? $urandom_range(1, 12)
                                                 : $urandom_range(13, 40);
                send_random_body(target, 1'b0);
            end
            if (ph == 1)
            begin
                // Pause the sender until the output side drains
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (exp_text_q.size() != 0);
            end
        end

        // Drain and finish
        s_tvalid <= 1'b0;
        while (exp_text_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
